FILE: sv/hds_pkg.sv
package hds_pkg;

  // Time counter width default; the top level hands it down as a parameter.
  localparam int DEF_TIME_BITS = 32;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int PCT_IN_W = 8;
  localparam int PCT_W    = 7;
  localparam int RAMP_W   = 16;
  localparam int PWM_W    = 8;
  localparam int PHASE_W  = 3;

  // Configuration port
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KICK_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_BELOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COAST       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd4;

  localparam logic       RST_KICK_ENABLE = 1'b1;
  localparam logic [9:0] RST_KICK_LENGTH = 10'd100;
  localparam logic [6:0] RST_KICK_BELOW  = 7'd70;
  localparam logic [9:0] RST_COAST       = 10'd70;
  localparam logic [7:0] RST_PERIOD      = 8'd15;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Ramp divider: quotient never exceeds the span, so it fits in PCT_W bits
  localparam int DIV_STEPS = PCT_W;
  localparam int PROD_W    = PCT_W + RAMP_W;
  localparam int DSH_W     = RAMP_W + DIV_STEPS - 1;

  // pwm = floor(pct * 255 / 100) = (pct * 255 * 5243) >> 19, exact for pct <= 100
  localparam int              PWM_RECIP_W = 21;
  localparam logic [20:0]     PWM_RECIP   = 21'd1336965;
  localparam int              PWM_SHIFT   = 19;
  localparam int              PWM_PROD_W  = PCT_W + PWM_RECIP_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_DRIVE = 2'd1,
    MODE_RAMP  = 2'd2,
    MODE_COAST = 2'd3
  } mode_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_STOPPED = 3'd0,
    PH_KICK    = 3'd1,
    PH_RAMP    = 3'd2,
    PH_HOLD    = 3'd3,
    PH_COAST   = 3'd4
  } phase_t;

  typedef struct packed {
    logic load;
    logic step;
    logic eval;
    logic mul;
    logic div;
    logic ramp_wr;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  eval_due;
    logic  is_ramp;
  } dp_status_t;

  function automatic logic [PWM_W-1:0] pwm_code(input logic [PCT_W-1:0] pct);
    logic [PWM_PROD_W-1:0] prod;
    prod = PWM_PROD_W'(pct) * PWM_PROD_W'(PWM_RECIP);
    return prod[PWM_SHIFT +: PWM_W];
  endfunction

endpackage

FILE: sv/hds_ctrl.sv
module hds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  hds_pkg::dp_status_t status,
  output hds_pkg::ctrl_cmd_t  cmd
);
  import hds_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_RWR,
    S_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.step     = (state == S_STEP);
    cmd.eval     = (state == S_EVAL);
    cmd.mul      = (state == S_MUL);
    cmd.div      = (state == S_DIV);
    cmd.ramp_wr  = (state == S_RWR);
    cmd.out_load = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_STEP;
        end
        S_STEP: begin
          state <= (status.mode == MODE_TICK) ? S_EVAL : S_OUT;
        end
        S_EVAL: begin
          state <= (status.eval_due && status.is_ramp) ? S_MUL : S_OUT;
        end
        S_MUL: begin
          cnt   <= CNT_W'(DIV_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_RWR;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_RWR: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while held");

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

endmodule

FILE: sv/hds_dpath.sv
module hds_dpath #(
  parameter int TIME_BITS = hds_pkg::DEF_TIME_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [hds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [hds_pkg::MODE_W-1:0]          mode,
  input  logic                                command_direction,
  input  logic [hds_pkg::PCT_IN_W-1:0]        requested_percent,
  input  logic [hds_pkg::RAMP_W-1:0]          ramp_ms,
  input  hds_pkg::ctrl_cmd_t                  cmd,
  output hds_pkg::dp_status_t                 status,
  output logic                                drive_direction,
  output logic [hds_pkg::PCT_W-1:0]           duty_percent,
  output logic [hds_pkg::PWM_W-1:0]           pwm_duty,
  output logic [hds_pkg::PHASE_W-1:0]         phase,
  output logic                                kick_applied,
  output logic [hds_pkg::PCT_W-1:0]           target_percent
);
  import hds_pkg::*;

  localparam int TB = TIME_BITS;

  // Configuration
  logic             kick_enable;
  logic [9:0]       kick_length_ms;
  logic [PCT_W-1:0] kick_below_percent;
  logic [9:0]       coast_time_ms;
  logic [7:0]       update_period_ms;

  // Captured item
  mode_t             in_mode;
  logic              in_dir;
  logic [PCT_W-1:0]  in_pct;
  logic [RAMP_W-1:0] in_rms;

  // Engine state
  phase_t            phase_reg, phase_reg_next;
  logic              active_direction, active_direction_next;
  logic [PCT_W-1:0]  current_percent, current_percent_next;
  logic [TB-1:0]     now_ms, now_ms_next;
  logic [TB-1:0]     last_update_ms, last_update_ms_next;
  logic [TB-1:0]     kick_end_ms, kick_end_ms_next;
  logic [PCT_W-1:0]  kick_settle, kick_settle_next;
  logic [TB-1:0]     ramp_start_ms, ramp_start_ms_next;
  logic [RAMP_W-1:0] ramp_length, ramp_length_next;
  logic [PCT_W-1:0]  ramp_from, ramp_from_next;
  logic [PCT_W-1:0]  ramp_to, ramp_to_next;
  logic [TB-1:0]     coast_end_ms, coast_end_ms_next;
  logic              pending_direction, pending_direction_next;
  logic [PCT_W-1:0]  pending_percent, pending_percent_next;
  logic              kick_flag, kick_flag_next;

  // Ramp work registers
  logic [RAMP_W-1:0] ramp_e;
  logic [RAMP_W-1:0] ramp_len_eff;
  logic              ramp_done;
  logic              ramp_down;
  logic [PCT_W-1:0]  span;
  logic [PROD_W-1:0] rem;
  logic [DSH_W-1:0]  divisor_sh;
  logic [PCT_W-1:0]  quotient;

  // Combinational helpers
  logic [TB-1:0]     since_update;
  logic [TB-1:0]     kick_diff;
  logic [TB-1:0]     coast_diff;
  logic [TB-1:0]     ramp_el;
  logic [RAMP_W-1:0] len_eff;
  logic              el_done;
  logic              running;
  logic              bd_go;
  logic              bd_dir;
  logic [PCT_W-1:0]  bd_pct;
  logic [PCT_W-1:0]  ramp_val;
  logic [PCT_W-1:0]  sat_pct;

  assign sat_pct = (requested_percent > PCT_IN_W'(PCT_MAX)) ? PCT_MAX
                                                           : requested_percent[PCT_W-1:0];

  assign since_update = now_ms - last_update_ms;
  assign kick_diff    = now_ms - kick_end_ms;
  assign coast_diff   = now_ms - coast_end_ms;
  assign ramp_el      = now_ms - ramp_start_ms;
  assign len_eff      = (ramp_length == '0) ? RAMP_W'(1) : ramp_length;
  assign el_done      = (ramp_el >= TB'(len_eff));
  assign running      = (current_percent != '0) && (phase_reg != PH_COAST);
  assign ramp_val     = ramp_down ? (ramp_from - quotient) : (ramp_from + quotient);

  assign status.mode     = in_mode;
  assign status.eval_due = (since_update >= TB'(update_period_ms));
  assign status.is_ramp  = (phase_reg == PH_RAMP);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kick_enable        <= RST_KICK_ENABLE;
      kick_length_ms     <= RST_KICK_LENGTH;
      kick_below_percent <= RST_KICK_BELOW;
      coast_time_ms      <= RST_COAST;
      update_period_ms   <= RST_PERIOD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KICK_ENABLE: kick_enable        <= cfg_data[0];
        CFG_KICK_LENGTH: kick_length_ms     <= cfg_data[9:0];
        CFG_KICK_BELOW:  kick_below_percent <= cfg_data[PCT_W-1:0];
        CFG_COAST:       coast_time_ms      <= cfg_data[9:0];
        CFG_PERIOD:      update_period_ms   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_mode <= mode_t'(mode);
      in_dir  <= command_direction;
      in_pct  <= sat_pct;
      in_rms  <= ramp_ms;
    end
  end

  // Next engine state
  always_comb begin
    phase_reg_next         = phase_reg;
    active_direction_next  = active_direction;
    current_percent_next   = current_percent;
    now_ms_next            = now_ms;
    last_update_ms_next    = last_update_ms;
    kick_end_ms_next       = kick_end_ms;
    kick_settle_next       = kick_settle;
    ramp_start_ms_next     = ramp_start_ms;
    ramp_length_next       = ramp_length;
    ramp_from_next         = ramp_from;
    ramp_to_next           = ramp_to;
    coast_end_ms_next      = coast_end_ms;
    pending_direction_next = pending_direction;
    pending_percent_next   = pending_percent;
    kick_flag_next         = kick_flag;
    bd_go                  = 1'b0;
    bd_dir                 = in_dir;
    bd_pct                 = in_pct;

    if (cmd.step) begin
      unique case (in_mode)
        MODE_TICK: begin
          now_ms_next = now_ms + 1'b1;
        end
        MODE_DRIVE, MODE_RAMP: begin
          if (running && (in_dir != active_direction)) begin
            current_percent_next   = '0;
            phase_reg_next         = PH_COAST;
            coast_end_ms_next      = now_ms + TB'(coast_time_ms);
            pending_direction_next = in_dir;
            pending_percent_next   = in_pct;
          end else if (phase_reg == PH_COAST) begin
            pending_direction_next = in_dir;
            pending_percent_next   = in_pct;
          end else if (in_mode == MODE_DRIVE) begin
            bd_go = 1'b1;
          end else begin
            kick_flag_next        = 1'b0;
            active_direction_next = in_dir;
            ramp_from_next        = current_percent;
            ramp_to_next          = in_pct;
            ramp_start_ms_next    = now_ms;
            ramp_length_next      = (in_rms == '0) ? RAMP_W'(1) : in_rms;
            phase_reg_next        = PH_RAMP;
          end
        end
        MODE_COAST: begin
          current_percent_next = '0;
          phase_reg_next       = PH_STOPPED;
        end
        default: ;
      endcase
    end

    if (cmd.eval && status.eval_due) begin
      last_update_ms_next = now_ms;
      if (phase_reg == PH_KICK && !kick_diff[TB-1]) begin
        current_percent_next = kick_settle;
        phase_reg_next       = (kick_settle == '0) ? PH_STOPPED : PH_HOLD;
      end else if (phase_reg == PH_COAST && !coast_diff[TB-1]) begin
        bd_go  = 1'b1;
        bd_dir = pending_direction;
        bd_pct = pending_percent;
      end
    end

    // Drive entry: kick from standstill when enabled and below the kick threshold, otherwise take the request at once
    if (bd_go) begin
      active_direction_next = bd_dir;
      if ((current_percent == '0) && (bd_pct != '0) && kick_enable
          && (bd_pct < kick_below_percent)) begin
        kick_flag_next       = 1'b1;
        kick_settle_next     = bd_pct;
        kick_end_ms_next     = now_ms + TB'(kick_length_ms);
        current_percent_next = PCT_MAX;
        phase_reg_next       = PH_KICK;
      end else begin
        kick_flag_next       = 1'b0;
        current_percent_next = bd_pct;
        phase_reg_next       = (bd_pct == '0) ? PH_STOPPED : PH_HOLD;
      end
    end

    if (cmd.ramp_wr) begin
      current_percent_next = ramp_val;
      if (ramp_done) begin
        phase_reg_next = (ramp_val == '0) ? PH_STOPPED : PH_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg         <= PH_STOPPED;
      active_direction  <= 1'b0;
      current_percent   <= '0;
      now_ms            <= '0;
      last_update_ms    <= '0;
      kick_end_ms       <= '0;
      kick_settle       <= '0;
      ramp_start_ms     <= '0;
      ramp_length       <= '0;
      ramp_from         <= '0;
      ramp_to           <= '0;
      coast_end_ms      <= '0;
      pending_direction <= 1'b0;
      pending_percent   <= '0;
      kick_flag         <= 1'b0;
    end else begin
      phase_reg         <= phase_reg_next;
      active_direction  <= active_direction_next;
      current_percent   <= current_percent_next;
      now_ms            <= now_ms_next;
      last_update_ms    <= last_update_ms_next;
      kick_end_ms       <= kick_end_ms_next;
      kick_settle       <= kick_settle_next;
      ramp_start_ms     <= ramp_start_ms_next;
      ramp_length       <= ramp_length_next;
      ramp_from         <= ramp_from_next;
      ramp_to           <= ramp_to_next;
      coast_end_ms      <= coast_end_ms_next;
      pending_direction <= pending_direction_next;
      pending_percent   <= pending_percent_next;
      kick_flag         <= kick_flag_next;
    end
  end

  // Ramp: prepare, multiply, then restoring division one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ramp_done    <= el_done;
      ramp_e       <= el_done ? len_eff : ramp_el[RAMP_W-1:0];
      ramp_len_eff <= len_eff;
      ramp_down    <= (ramp_to < ramp_from);
      span         <= (ramp_to < ramp_from) ? (ramp_from - ramp_to) : (ramp_to - ramp_from);
    end
    if (cmd.mul) begin
      rem        <= PROD_W'(span) * PROD_W'(ramp_e);
      divisor_sh <= DSH_W'(ramp_len_eff) << (DIV_STEPS - 1);
      quotient   <= '0;
    end
    if (cmd.div) begin
      if (rem >= PROD_W'(divisor_sh)) begin
        rem      <= rem - PROD_W'(divisor_sh);
        quotient <= {quotient[PCT_W-2:0], 1'b1};
      end else begin
        quotient <= {quotient[PCT_W-2:0], 1'b0};
      end
      divisor_sh <= divisor_sh >> 1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive_direction <= active_direction;
      duty_percent    <= current_percent;
      pwm_duty        <= pwm_code(current_percent);
      phase           <= phase_reg;
      kick_applied    <= kick_flag;
      unique case (phase_reg)
        PH_KICK:  target_percent <= kick_settle;
        PH_RAMP:  target_percent <= ramp_to;
        PH_COAST: target_percent <= pending_percent;
        default:  target_percent <= current_percent;
      endcase
    end
  end

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    current_percent <= PCT_MAX)
    else $error("duty above full scale");

  a_quot_span: assert property (@(posedge clk) disable iff (rst)
    cmd.ramp_wr |-> quotient <= span)
    else $error("ramp step beyond its span");

  a_kick_flag: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_KICK |-> kick_flag)
    else $error("kick phase without kick flag");

endmodule

FILE: sv/hbridge_drive_sequencer_core.sv
// H-bridge drive sequencer: soft-start kick, linear ramps, coast before reversal.
//
// Input channel (in_valid / in_stall): one item per command or per 1 ms tick.
//   mode selects tick, instant drive, ramped drive or forced coast; the other
//   fields carry direction, requested percent (saturates at 100) and ramp length.
// Output channel (out_valid / out_stall): exactly one result item per input item,
//   giving the state after that item: direction, duty, 8-bit PWM code, phase,
//   kick flag and the percent the current phase is heading to.
// Configuration (cfg_write / cfg_index / cfg_data): write registers only while idle.
//
// Sequencing: a command passes the step state, then loads the result register; a
// tick passes step and evaluate; a tick that evaluates an active ramp also passes
// multiply, divide and ramp write: the ramp position goes through one multiply and
// a 7-step restoring divider that produces one quotient bit per cycle. One item is
// in flight at a time: the next is taken once the last has left the output state.
// The result register frees the input side: a new item is taken while the last
// result still waits. If the receiver stalls and a new result is finished, the
// block holds in its output state until the register is taken.
// Reset: engine stopped, forward, all timers 0, registers at their defaults.
module hbridge_drive_sequencer_core #(
  parameter int TIME_BITS = hds_pkg::DEF_TIME_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [hds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hds_pkg::MODE_W-1:0]     mode,
  input  logic                           command_direction,
  input  logic [hds_pkg::PCT_IN_W-1:0]   requested_percent,
  input  logic [hds_pkg::RAMP_W-1:0]     ramp_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           drive_direction,
  output logic [hds_pkg::PCT_W-1:0]      duty_percent,
  output logic [hds_pkg::PWM_W-1:0]      pwm_duty,
  output logic [hds_pkg::PHASE_W-1:0]    phase,
  output logic                           kick_applied,
  output logic [hds_pkg::PCT_W-1:0]      target_percent
);
  import hds_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence each item: capture, apply, evaluate timers, ramp math, publish
  hds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold engine state, timers, ramp divider and the result register
  hds_dpath #(
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mode              (mode),
    .command_direction (command_direction),
    .requested_percent (requested_percent),
    .ramp_ms           (ramp_ms),
    .cmd               (cmd),
    .status            (status),
    .drive_direction   (drive_direction),
    .duty_percent      (duty_percent),
    .pwm_duty          (pwm_duty),
    .phase             (phase),
    .kick_applied      (kick_applied),
    .target_percent    (target_percent)
  );

endmodule
